// File: src/disc_pair_collision_resolve_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the disc pair collision resolver
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISC_PAIR_COLLISION_RESOLVE_MACROS_SVH
`define DISC_PAIR_COLLISION_RESOLVE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DPCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// expression never true
`define DPCR_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// File: src/dpcr_pkg.sv
// ----------------------------------------------------------------------------
// dpcr_pkg
// Types and constants shared by the disc pair collision resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package dpcr_pkg;

  localparam int CFG_W  = 17;
  localparam int LANES  = 4;
  localparam int F_W    = 51;   // mass * (1+e) * |d axis|
  localparam int P_W    = 52;   // |relative velocity . d|
  localparam int DEN_W  = 51;   // (mass sum) * |d|^2
  localparam int Q_W    = 34;   // quotient bits before the cap
  localparam int N_W    = 87;   // product >> 16
  localparam int SPLIT  = 26;   // partial product split point

  localparam int FRONT_LAT = 4;
  localparam int LANE_LAT  = 3 + Q_W + 1;
  localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT;

  localparam logic [CFG_W-1:0] RESTITUTION_RST = 17'h10000;
  localparam logic [17:0]      EP_ONE          = 18'h10000;
  localparam logic [Q_W-1:0]   DELTA_CAP       = 34'h2_0000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x_a;
    logic signed [31:0] pos_y_a;
    logic signed [31:0] vel_x_a;
    logic signed [31:0] vel_y_a;
    logic [15:0]        mass_a;
    logic [15:0]        radius_a;
    logic signed [31:0] pos_x_b;
    logic signed [31:0] pos_y_b;
    logic signed [31:0] vel_x_b;
    logic signed [31:0] vel_y_b;
    logic [15:0]        mass_b;
    logic [15:0]        radius_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x_a;
    logic signed [31:0] new_vel_y_a;
    logic signed [31:0] new_vel_x_b;
    logic signed [31:0] new_vel_y_b;
    logic               collided;
  } out_word_t;

  // one velocity component's update job
  typedef struct packed {
    logic [F_W-1:0]     f;
    logic [P_W-1:0]     absp;
    logic [DEN_W-1:0]   den;
    logic signed [31:0] vel;
    logic               neg;
    logic               en;
  } lane_in_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } front_ctl_t;

endpackage

`default_nettype wire

// File: src/disc_pair_collision_resolve.sv
// ----------------------------------------------------------------------------
// disc_pair_collision_resolve
// Resolves a two-disc collision with restitution in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Stages: 4 geometry stages, 2 product stages, 1 divide setup, 34 divide bit
//   stages and 1 apply/saturate stage lie between the accepting edge and the
//   out_valid strobe cycle.
// Throughput: one word per cycle; busy stays low once out of reset.
// Results cannot be stalled; each is shown for one cycle on out_valid.
// Reset: synchronous active-low rst_n flushes all valid bits, sets the
//   restitution to 1.0 and holds busy high through the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "disc_pair_collision_resolve_macros.svh"

module disc_pair_collision_resolve (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input words
  input  wire logic                        start,
  output logic                             busy,
  input  wire dpcr_pkg::in_word_t          in_data,
  // results
  output logic                             out_valid,
  output dpcr_pkg::out_word_t              out_data,
  // restitution register write
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [dpcr_pkg::CFG_W-1:0]  cfg_data
);
  import dpcr_pkg::*;

  logic             busy_r;
  logic [CFG_W-1:0] rest_r;
  front_ctl_t       ctl;
  lane_in_t         lane_in [LANES];
  logic signed [31:0] lane_vel [LANES];

  // valid and hit follow the lanes through the divider
  logic             vld_r [LANE_LAT];
  logic             hit_r [LANE_LAT];

  // busy only covers reset; the pipeline never backs up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // restitution is sampled into each word at stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= RESTITUTION_RST;
    end else if (cfg_valid && cfg_ready) begin
      rest_r <= cfg_data;
    end
  end

  dpcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (start && !busy_r),
    .in_data     (in_data),
    .restitution (rest_r),
    .ctl_o       (ctl),
    .lane_o      (lane_in)
  );

  // lanes: A x, A y, B x, B y
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    dpcr_lane u_lane (
      .clk    (clk),
      .lane_i (lane_in[i]),
      .vel_o  (lane_vel[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= ctl.valid;
      for (int i = 1; i < LANE_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
    hit_r[0] <= ctl.hit;
    for (int i = 1; i < LANE_LAT; i++) begin
      hit_r[i] <= hit_r[i-1];
    end
  end

  assign out_valid            = vld_r[LANE_LAT-1];
  assign out_data.new_vel_x_a = lane_vel[0];
  assign out_data.new_vel_y_a = lane_vel[1];
  assign out_data.new_vel_x_b = lane_vel[2];
  assign out_data.new_vel_y_b = lane_vel[3];
  assign out_data.collided    = vld_r[LANE_LAT-1] && hit_r[LANE_LAT-1];

  // every result traces back to an accepted word that entered the full pipeline
  `DPCR_ASSERT_IMPL(a_out_has_source, out_valid, $past(start && !busy, TOTAL_LAT), "result without accepted word")
  // a miss leaves velocities untouched
  `DPCR_ASSERT_IMPL(a_miss_vx_a, out_valid && !out_data.collided, out_data.new_vel_x_a == $past(in_data.vel_x_a, TOTAL_LAT), "miss changed A x velocity")
  `DPCR_ASSERT_IMPL(a_miss_vy_b, out_valid && !out_data.collided, out_data.new_vel_y_b == $past(in_data.vel_y_b, TOTAL_LAT), "miss changed B y velocity")
  // busy drops for good after reset
  `DPCR_ASSERT_IMPL(a_busy_low, $past(rst_n), !busy, "busy high outside reset")
  `DPCR_ASSERT_NEVER(a_hit_idle, out_data.collided && !out_valid, "collided flag without result")

endmodule

`default_nettype wire

// File: src/dpcr_front.sv
// ----------------------------------------------------------------------------
// dpcr_front
// Geometry pipeline: offsets, squared distance, approach product, hit test
// and the per-component numerators and denominator. Four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcr_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire dpcr_pkg::in_word_t          in_data,
  input  wire logic [dpcr_pkg::CFG_W-1:0]  restitution,
  output dpcr_pkg::front_ctl_t             ctl_o,
  output dpcr_pkg::lane_in_t               lane_o [dpcr_pkg::LANES]
);
  import dpcr_pkg::*;

  // stage A
  logic               va_r;
  logic signed [32:0] dx_a_r, dy_a_r, dvx_a_r, dvy_a_r;
  logic [16:0]        rsum_a_r;
  logic [17:0]        ep_a_r;
  logic [15:0]        ma_a_r, mb_a_r;
  logic signed [31:0] vel_a_r [LANES];

  // stage B
  logic               vb_r, inbox_b_r, negx_b_r, negy_b_r;
  logic [16:0]        adx_b_r, ady_b_r, msum_b_r;
  logic [33:0]        sqx_b_r, sqy_b_r, rsq_b_r, mea_b_r, meb_b_r;
  logic signed [50:0] pdx_b_r, pdy_b_r;
  logic signed [31:0] vel_b_r [LANES];

  // stage C
  logic               vc_r, inbox_c_r, negx_c_r, negy_c_r;
  logic [34:0]        d2_c_r;
  logic signed [51:0] p_c_r;
  logic [33:0]        rsq_c_r;
  logic [16:0]        msum_c_r;
  logic [F_W-1:0]     f_c_r [LANES];
  logic signed [31:0] vel_c_r [LANES];

  // stage D
  front_ctl_t         ctl_d_r;
  lane_in_t           lane_d_r [LANES];

  logic signed [32:0] rs33, nrs33;
  logic signed [17:0] dx18, dy18;
  logic [17:0]        adx18, ady18;
  logic               hit_nxt;
  logic [P_W-1:0]     absp_nxt;
  logic [DEN_W-1:0]   den_nxt;

  // ---- stage A: differences ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
    dx_a_r     <= {in_data.pos_x_a[31], in_data.pos_x_a} - {in_data.pos_x_b[31], in_data.pos_x_b};
    dy_a_r     <= {in_data.pos_y_a[31], in_data.pos_y_a} - {in_data.pos_y_b[31], in_data.pos_y_b};
    dvx_a_r    <= {in_data.vel_x_a[31], in_data.vel_x_a} - {in_data.vel_x_b[31], in_data.vel_x_b};
    dvy_a_r    <= {in_data.vel_y_a[31], in_data.vel_y_a} - {in_data.vel_y_b[31], in_data.vel_y_b};
    rsum_a_r   <= 17'(in_data.radius_a) + 17'(in_data.radius_b);
    ep_a_r     <= 18'(restitution) + EP_ONE;
    ma_a_r     <= in_data.mass_a;
    mb_a_r     <= in_data.mass_b;
    vel_a_r[0] <= in_data.vel_x_a;
    vel_a_r[1] <= in_data.vel_y_a;
    vel_a_r[2] <= in_data.vel_x_b;
    vel_a_r[3] <= in_data.vel_y_b;
  end

  // ---- stage B: box test and products ----
  always_comb begin
    rs33  = signed'({16'd0, rsum_a_r});
    nrs33 = -rs33;
    dx18  = dx_a_r[17:0];
    dy18  = dy_a_r[17:0];
    adx18 = dx_a_r[32] ? 18'(-dx18) : dx_a_r[17:0];
    ady18 = dy_a_r[32] ? 18'(-dy18) : dy_a_r[17:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    inbox_b_r <= (dx_a_r < rs33) && (dx_a_r > nrs33) && (dy_a_r < rs33) && (dy_a_r > nrs33);
    negx_b_r  <= dx_a_r[32];
    negy_b_r  <= dy_a_r[32];
    adx_b_r   <= adx18[16:0];
    ady_b_r   <= ady18[16:0];
    sqx_b_r   <= 34'(adx18[16:0]) * 34'(adx18[16:0]);
    sqy_b_r   <= 34'(ady18[16:0]) * 34'(ady18[16:0]);
    rsq_b_r   <= 34'(rsum_a_r) * 34'(rsum_a_r);
    pdx_b_r   <= 51'(dvx_a_r) * 51'(dx18);
    pdy_b_r   <= 51'(dvy_a_r) * 51'(dy18);
    mea_b_r   <= 34'(ma_a_r) * 34'(ep_a_r);
    meb_b_r   <= 34'(mb_a_r) * 34'(ep_a_r);
    msum_b_r  <= 17'(ma_a_r) + 17'(mb_a_r);
    vel_b_r   <= vel_a_r;
  end

  // ---- stage C: sums and numerators ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
    inbox_c_r <= inbox_b_r;
    negx_c_r  <= negx_b_r;
    negy_c_r  <= negy_b_r;
    d2_c_r    <= 35'(sqx_b_r) + 35'(sqy_b_r);
    p_c_r     <= 52'(pdx_b_r) + 52'(pdy_b_r);
    rsq_c_r   <= rsq_b_r;
    msum_c_r  <= msum_b_r;
    f_c_r[0]  <= F_W'(meb_b_r) * F_W'(adx_b_r);
    f_c_r[1]  <= F_W'(meb_b_r) * F_W'(ady_b_r);
    f_c_r[2]  <= F_W'(mea_b_r) * F_W'(adx_b_r);
    f_c_r[3]  <= F_W'(mea_b_r) * F_W'(ady_b_r);
    vel_c_r   <= vel_b_r;
  end

  // ---- stage D: hit decision, magnitude, denominator ----
  always_comb begin
    hit_nxt  = inbox_c_r && (d2_c_r < 35'(rsq_c_r)) && p_c_r[51];
    absp_nxt = p_c_r[51] ? P_W'(-p_c_r) : P_W'(p_c_r);
    den_nxt  = DEN_W'(msum_c_r) * DEN_W'(d2_c_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r.valid <= 1'b0;
    end else begin
      ctl_d_r.valid <= vc_r;
    end
    ctl_d_r.hit <= hit_nxt;
    for (int i = 0; i < LANES; i++) begin
      lane_d_r[i].f    <= f_c_r[i];
      lane_d_r[i].absp <= absp_nxt;
      lane_d_r[i].den  <= den_nxt;
      lane_d_r[i].vel  <= vel_c_r[i];
      lane_d_r[i].en   <= hit_nxt;
    end
    // A moves along d, B against d
    lane_d_r[0].neg <= negx_c_r;
    lane_d_r[1].neg <= negy_c_r;
    lane_d_r[2].neg <= !negx_c_r;
    lane_d_r[3].neg <= !negy_c_r;
  end

  assign ctl_o  = ctl_d_r;
  assign lane_o = lane_d_r;

endmodule

`default_nettype wire

// File: src/dpcr_lane.sv
// ----------------------------------------------------------------------------
// dpcr_lane
// One velocity component: wide product, pipelined restoring divide
// (one quotient bit per stage), cap, signed add and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcr_lane (
  input  wire logic               clk,
  input  wire dpcr_pkg::lane_in_t lane_i,
  output logic signed [31:0]      vel_o
);
  import dpcr_pkg::*;

  // L1: partial products
  logic [51:0]        pll_r, plh_r, phl_r, phh_r;
  logic [DEN_W-1:0]   den1_r;
  logic signed [31:0] vel1_r;
  logic               neg1_r, en1_r;

  // L2: shifted product
  logic [N_W-1:0]     n2_r;
  logic [DEN_W-1:0]   den2_r;
  logic signed [31:0] vel2_r;
  logic               neg2_r, en2_r;
  logic [102:0]       nfull;

  // divider stages, index 0 is the setup stage
  logic [DEN_W-1:0]   rem_r  [Q_W+1];
  logic [Q_W-1:0]     q_r    [Q_W+1];
  logic [Q_W-1:0]     nlo_r  [Q_W+1];
  logic [DEN_W-1:0]   den_r  [Q_W+1];
  logic               ovf_r  [Q_W+1];
  logic               zero_r [Q_W+1];
  logic signed [31:0] vel_r  [Q_W+1];
  logic               neg_r  [Q_W+1];

  logic [52:0]        top53;
  logic [Q_W-1:0]     mag;
  logic signed [34:0] sum35;
  logic signed [31:0] vel_o_r, vel_o_nxt;

  always_ff @(posedge clk) begin
    pll_r  <= 52'(lane_i.f[SPLIT-1:0])   * 52'(lane_i.absp[SPLIT-1:0]);
    plh_r  <= 52'(lane_i.f[SPLIT-1:0])   * 52'(lane_i.absp[P_W-1:SPLIT]);
    phl_r  <= 52'(lane_i.f[F_W-1:SPLIT]) * 52'(lane_i.absp[SPLIT-1:0]);
    phh_r  <= 52'(lane_i.f[F_W-1:SPLIT]) * 52'(lane_i.absp[P_W-1:SPLIT]);
    den1_r <= lane_i.den;
    vel1_r <= lane_i.vel;
    neg1_r <= lane_i.neg;
    en1_r  <= lane_i.en;
  end

  assign nfull = 103'(pll_r) + (103'(plh_r) << SPLIT) + (103'(phl_r) << SPLIT)
               + (103'(phh_r) << (2 * SPLIT));

  always_ff @(posedge clk) begin
    n2_r   <= nfull[102:16];
    den2_r <= den1_r;
    vel2_r <= vel1_r;
    neg2_r <= neg1_r;
    en2_r  <= en1_r;
  end

  // setup: quotient overflow check, first remainder
  assign top53 = n2_r[N_W-1:Q_W];

  always_ff @(posedge clk) begin
    rem_r[0]  <= top53[DEN_W-1:0];
    q_r[0]    <= '0;
    nlo_r[0]  <= n2_r[Q_W-1:0];
    den_r[0]  <= den2_r;
    ovf_r[0]  <= top53 >= 53'(den2_r);
    zero_r[0] <= !en2_r || (den2_r == '0);
    vel_r[0]  <= vel2_r;
    neg_r[0]  <= neg2_r;
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_div
    logic [DEN_W:0] remsh, diff;
    logic           ge;

    always_comb begin
      remsh = {rem_r[s], nlo_r[s][Q_W-1]};
      diff  = remsh - {1'b0, den_r[s]};
      ge    = remsh >= {1'b0, den_r[s]};
    end

    always_ff @(posedge clk) begin
      rem_r[s+1]  <= ge ? diff[DEN_W-1:0] : remsh[DEN_W-1:0];
      q_r[s+1]    <= {q_r[s][Q_W-2:0], ge};
      nlo_r[s+1]  <= nlo_r[s] << 1;
      den_r[s+1]  <= den_r[s];
      ovf_r[s+1]  <= ovf_r[s];
      zero_r[s+1] <= zero_r[s];
      vel_r[s+1]  <= vel_r[s];
      neg_r[s+1]  <= neg_r[s];
    end
  end

  // cap, apply, saturate
  always_comb begin
    if (zero_r[Q_W]) begin
      mag = '0;
    end else if (ovf_r[Q_W] || (q_r[Q_W] > DELTA_CAP)) begin
      mag = DELTA_CAP;
    end else begin
      mag = q_r[Q_W];
    end
    if (neg_r[Q_W]) begin
      sum35 = 35'(vel_r[Q_W]) - signed'({1'b0, mag});
    end else begin
      sum35 = 35'(vel_r[Q_W]) + signed'({1'b0, mag});
    end
    if (sum35[34:31] == 4'b0000 || sum35[34:31] == 4'b1111) begin
      vel_o_nxt = sum35[31:0];
    end else if (sum35[34]) begin
      vel_o_nxt = 32'sh8000_0000;
    end else begin
      vel_o_nxt = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    vel_o_r <= vel_o_nxt;
  end

  assign vel_o = vel_o_r;

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: disc pair collision resolver testbench
// Drives disc pairs through the command port, predicts each result from an
// internal fixed-point model and checks every strobed word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpcr_pkg::*;

  // Expected-result store and collision predictor.
  class collision_board;
    out_word_t pending[$];
    logic [16:0] rest;
    int errors;
    int hits;

    function new();
      rest = 17'h10000;
      errors = 0;
      hits = 0;
    endfunction

    // floor(f * absp / 2^16 / den), capped at 2^33
    function logic [63:0] change(logic [63:0] f, logic [63:0] absp, logic [63:0] den);
      logic [127:0] num;
      logic [127:0] q;
      if (den == 0) return 64'd0;
      num = ({64'd0, f} * {64'd0, absp}) >> 16;
      q = num / {64'd0, den};
      if (q > 128'h2_0000_0000) return 64'h2_0000_0000;
      return q[63:0];
    endfunction

    function logic signed [31:0] apply(longint v, logic [63:0] m, bit neg);
      longint r;
      r = neg ? v - longint'(m) : v + longint'(m);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    function void note_pair(in_word_t w);
      out_word_t o;
      longint dx, dy, rs, d2, p;
      logic [63:0] ep, absp, den, adx, ady, ma, mb;
      dx = longint'(w.pos_x_a) - longint'(w.pos_x_b);
      dy = longint'(w.pos_y_a) - longint'(w.pos_y_b);
      rs = longint'(w.radius_a) + longint'(w.radius_b);
      o.new_vel_x_a = w.vel_x_a;
      o.new_vel_y_a = w.vel_y_a;
      o.new_vel_x_b = w.vel_x_b;
      o.new_vel_y_b = w.vel_y_b;
      o.collided = 1'b0;
      if (dx < rs && dx > -rs && dy < rs && dy > -rs) begin
        d2 = dx * dx + dy * dy;
        p = (longint'(w.vel_x_a) - longint'(w.vel_x_b)) * dx
          + (longint'(w.vel_y_a) - longint'(w.vel_y_b)) * dy;
        if (d2 < rs * rs && p < 0) begin
          ma = w.mass_a;
          mb = w.mass_b;
          ep = 64'h10000 + rest;
          absp = -p;
          den = (ma + mb) * d2;
          adx = dx < 0 ? -dx : dx;
          ady = dy < 0 ? -dy : dy;
          o.collided = 1'b1;
          o.new_vel_x_a = apply(w.vel_x_a, change(mb * ep * adx, absp, den), dx < 0);
          o.new_vel_y_a = apply(w.vel_y_a, change(mb * ep * ady, absp, den), dy < 0);
          o.new_vel_x_b = apply(w.vel_x_b, change(ma * ep * adx, absp, den), dx > 0);
          o.new_vel_y_b = apply(w.vel_y_b, change(ma * ep * ady, absp, den), dy > 0);
          hits++;
        end
      end
      pending.push_back(o);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.new_vel_x_a !== exp_w.new_vel_x_a ||
          got.new_vel_y_a !== exp_w.new_vel_y_a ||
          got.new_vel_x_b !== exp_w.new_vel_x_b ||
          got.new_vel_y_b !== exp_w.new_vel_y_b ||
          got.collided !== exp_w.collided) begin
        $display("%0t: mismatch expected %h actual %h", $realtime, exp_w, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_data = '0;
  logic out_valid;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  collision_board board = new();
  bit calm = 0;          // no idling in the closing stretch
  int pairs_sent = 0;

  disc_pair_collision_resolve dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // results cannot be held off: check every strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_word(out_data);
  end

  // push one word; start stays high across back-to-back words
  task automatic send_pair(in_word_t w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_data <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_pair(w);
    pairs_sent++;
    @(negedge clk);
  endtask

  // wait for quiet, then write the restitution register
  task automatic set_restitution(logic [16:0] e);
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_data <= e;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.rest = e;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rnd32();
    return $urandom;
  endfunction

  // random pair; mostly overlapping discs, the rest far apart or raw noise
  function automatic in_word_t rand_pair();
    in_word_t w;
    int k;
    k = $urandom_range(0, 9);
    w.mass_a = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(1, 40));
    w.mass_b = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(1, 40));
    w.radius_a = 16'($urandom);
    w.radius_b = 16'($urandom);
    w.pos_x_a = rnd32();
    w.pos_y_a = rnd32();
    w.vel_x_a = k < 2 ? rnd32() : 32'($signed($urandom_range(0, 262143)) - 131072);
    w.vel_y_a = k < 2 ? rnd32() : 32'($signed($urandom_range(0, 262143)) - 131072);
    w.vel_x_b = k < 2 ? rnd32() : 32'($signed($urandom_range(0, 262143)) - 131072);
    w.vel_y_b = k < 2 ? rnd32() : 32'($signed($urandom_range(0, 262143)) - 131072);
    if (k >= 1) begin
      // near contact: offset within about the radius sum
      w.pos_x_b = w.pos_x_a + 32'($signed($urandom_range(0, 131070)) - 65535);
      w.pos_y_b = w.pos_y_a + 32'($signed($urandom_range(0, 131070)) - 65535);
    end else begin
      w.pos_x_b = rnd32();
      w.pos_y_b = rnd32();
    end
    return w;
  endfunction

  initial begin
    in_word_t w;
    logic [16:0] e_set[5];
    e_set = '{17'h10000, 17'h0, 17'h1FFFF, 17'h8000, 17'h0C000};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, coincident centers, zero masses, saturation
    set_restitution(17'h10000);
    w = '0; send_pair(w);                        // coincident, all zero
    w = '1; send_pair(w);
    w = '0; w.radius_a = 16'hFFFF; w.radius_b = 16'hFFFF;
    w.pos_x_a = 32'h1000; w.vel_x_a = 32'hFFFF_0000; w.mass_a = 16'd1; w.mass_b = 16'd1;
    send_pair(w);                                // head-on hit
    w.mass_a = 16'd0; w.mass_b = 16'd0; send_pair(w); // both masses zero
    w.mass_a = 16'hFFFF; send_pair(w);            // one mass zero
    w.mass_a = 16'd1; w.mass_b = 16'hFFFF; w.vel_x_a = 32'h8000_0000;
    w.vel_x_b = 32'h7FFF_FFFF; w.pos_x_a = 32'h1; send_pair(w); // saturate
    w.vel_x_a = 32'h0001_0000; send_pair(w);      // still approaching, a hit
    w.pos_x_a = 32'h7FFF_FFFF; w.pos_x_b = 32'h8000_0000; send_pair(w);
    w = '0; w.radius_a = 16'h8000; w.radius_b = 16'h8000;
    w.pos_x_a = 32'h8000; w.pos_y_a = 32'h8000; w.mass_a = 16'd3; w.mass_b = 16'd5;
    w.vel_x_a = 32'hFFFF_8000; w.vel_y_b = 32'h0000_4000; send_pair(w);
    w.pos_x_a = 32'h10000; w.pos_y_a = '0; send_pair(w); // touching, not overlapping
    set_restitution(17'h1FFFF);
    w.pos_x_a = 32'hFFFF_0001; w.vel_x_a = 32'h0001_0000; send_pair(w);
    set_restitution(17'h0);
    send_pair(w);

    // random phases over several restitution settings
    for (int ph = 0; ph < 5; ph++) begin
      set_restitution(ph == 4 ? 17'($urandom_range(0, 131071)) : e_set[ph]);
      if (ph == 4) calm = 1;
      repeat (280) send_pair(rand_pair());
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d disc pairs over six restitution settings, %0d predicted hits.",
             pairs_sent, board.hits);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
